// File: src/etb_pkg.sv
// etb_pkg: shared types, constants and arithmetic helpers for the
// euler_to_basis_vectors block. No dependencies.
package etb_pkg;

  localparam int ANGLE_FRAC_BITS_DEF = 7;
  localparam int OUT_FRAC_BITS_DEF   = 14;
  localparam int CORDIC_STAGES_DEF   = 16;

  localparam int N_AXES   = 3;
  localparam int IN_W     = 17;
  localparam int OUT_W    = 16;
  localparam int Q_FRAC   = 30;
  localparam int Z_FRAC   = 24;
  localparam int XY_W     = 33;
  localparam int Z_W      = 34;
  localparam int P_W      = 34;
  localparam int MUL_W    = 2 * XY_W;

  localparam longint CORDIC_X0     = 652032874;
  localparam longint DEG_PER_RAD_Z = 961263669;

  typedef logic signed [IN_W-1:0]  angle_t;
  typedef logic signed [XY_W-1:0]  xy_t;
  typedef logic signed [Z_W-1:0]   z_t;
  typedef logic signed [P_W-1:0]   sum_t;
  typedef logic signed [OUT_W-1:0] comp_t;

  // one rotator lane: cosine, sine, residual angle and quadrant fold flag
  typedef struct packed {
    xy_t  x;
    xy_t  y;
    z_t   z;
    logic neg;
  } lane_t;

  typedef lane_t [N_AXES-1:0] lanes_t;

  typedef struct packed {
    comp_t forward_x;
    comp_t forward_y;
    comp_t forward_z;
    comp_t right_x;
    comp_t right_y;
    comp_t right_z;
    comp_t up_x;
    comp_t up_y;
    comp_t up_z;
  } vec_t;

  // arctangent of 2^-i in degrees, 24 fraction bits
  function automatic z_t atan_entry(input int i);
    longint v;
    begin
      case (i)
        0:       v = 754974720;
        1:       v = 445687602;
        2:       v = 235489088;
        3:       v = 119537938;
        4:       v = 60000934;
        5:       v = 30029717;
        6:       v = 15018523;
        7:       v = 7509720;
        8:       v = 3754917;
        9:       v = 1877466;
        10:      v = 938734;
        11:      v = 469367;
        default: v = (DEG_PER_RAD_Z + (64'sd1 <<< (i - 1))) >>> i;
      endcase
      return Z_W'(v);
    end
  endfunction

  // q30 product, rounded half up
  function automatic xy_t qmul(input xy_t a, input xy_t b);
    logic signed [MUL_W-1:0] p;
    begin
      p = MUL_W'(a) * MUL_W'(b);
      p = p + (MUL_W'(1) <<< (Q_FRAC - 1));
      return XY_W'(p >>> Q_FRAC);
    end
  endfunction

endpackage

// File: src/etb_if.sv
// etb_if: valid/ready channels for angle triples and basis vectors.
// Depends on etb_pkg.
interface etb_angle_if import etb_pkg::*; ();
  logic   valid;
  logic   ready;
  angle_t pitch_angle;
  angle_t yaw_angle;
  angle_t roll_angle;

  modport source (output valid, pitch_angle, yaw_angle, roll_angle, input ready);
  modport sink   (input valid, pitch_angle, yaw_angle, roll_angle, output ready);
endinterface

interface etb_vec_if import etb_pkg::*; ();
  logic  valid;
  logic  ready;
  comp_t forward_x;
  comp_t forward_y;
  comp_t forward_z;
  comp_t right_x;
  comp_t right_y;
  comp_t right_z;
  comp_t up_x;
  comp_t up_y;
  comp_t up_z;

  modport source (output valid, forward_x, forward_y, forward_z, right_x, right_y,
                  right_z, up_x, up_y, up_z, input ready);
  modport sink   (input valid, forward_x, forward_y, forward_z, right_x, right_y,
                  right_z, up_x, up_y, up_z, output ready);
endinterface

// File: src/etb_reduce.sv
// etb_reduce: folds each angle into [-90, 90] degrees and loads the rotator
// lanes. Depends on etb_pkg.
module etb_reduce import etb_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   valid_i,
  output logic   ready_o,
  input  angle_t angle_i [N_AXES],
  output logic   valid_o,
  input  logic   ready_i,
  output lanes_t lanes_o
);

  localparam int FULL    = 360 << ANGLE_FRAC_BITS;
  localparam int HALF    = 180 << ANGLE_FRAC_BITS;
  localparam int QUARTER = 90 << ANGLE_FRAC_BITS;
  localparam int KMAX    = (65536 + HALF) / FULL + 1;
  localparam int RW      = 26;

  logic   valid_q;
  lanes_t lanes_q;
  lanes_t lanes_d;

  // wrap into one turn by picking the multiple that lands in range, then fold
  always_comb begin
    logic signed [RW-1:0] c;
    logic signed [RW-1:0] r;
    logic                 neg;
    for (int a = 0; a < N_AXES; a++) begin
      r = '0;
      for (int k = -KMAX; k <= KMAX; k++) begin
        c = RW'(angle_i[a]) + RW'(k * FULL);
        if (c >= RW'(-HALF) && c < RW'(HALF)) begin
          r = c;
        end
      end
      neg = 1'b0;
      if (r > RW'(QUARTER)) begin
        r   = r - RW'(HALF);
        neg = 1'b1;
      end else if (r < RW'(-QUARTER)) begin
        r   = r + RW'(HALF);
        neg = 1'b1;
      end
      lanes_d[a].x   = XY_W'(CORDIC_X0);
      lanes_d[a].y   = '0;
      lanes_d[a].z   = Z_W'(r) <<< (Z_FRAC - ANGLE_FRAC_BITS);
      lanes_d[a].neg = neg;
    end
  end

  assign ready_o = !valid_q || ready_i;

  // stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // stage data
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      lanes_q <= lanes_d;
    end
  end

  assign valid_o = valid_q;
  assign lanes_o = lanes_q;

endmodule

// File: src/etb_cordic_cell.sv
// etb_cordic_cell: one rotation-mode cordic step for all three angle lanes,
// registered. Depends on etb_pkg.
module etb_cordic_cell import etb_pkg::*; #(
  parameter int STAGE = 0
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   valid_i,
  output logic   ready_o,
  input  lanes_t lanes_i,
  output logic   valid_o,
  input  logic   ready_i,
  output lanes_t lanes_o
);

  localparam z_t ATAN = atan_entry(STAGE);

  logic   valid_q;
  lanes_t lanes_q;
  lanes_t lanes_d;

  // rotate toward zero residual angle
  always_comb begin
    xy_t xs;
    xy_t ys;
    for (int a = 0; a < N_AXES; a++) begin
      xs = lanes_i[a].x >>> STAGE;
      ys = lanes_i[a].y >>> STAGE;
      lanes_d[a].neg = lanes_i[a].neg;
      if (!lanes_i[a].z[Z_W-1]) begin
        lanes_d[a].x = lanes_i[a].x - ys;
        lanes_d[a].y = lanes_i[a].y + xs;
        lanes_d[a].z = lanes_i[a].z - ATAN;
      end else begin
        lanes_d[a].x = lanes_i[a].x + ys;
        lanes_d[a].y = lanes_i[a].y - xs;
        lanes_d[a].z = lanes_i[a].z + ATAN;
      end
    end
  end

  assign ready_o = !valid_q || ready_i;

  // stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // stage data
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      lanes_q <= lanes_d;
    end
  end

  assign valid_o = valid_q;
  assign lanes_o = lanes_q;

endmodule

// File: src/etb_combine.sv
// etb_combine: three registered stages that form the basis vector products,
// sums and rounding to the output format. Depends on etb_pkg.
module etb_combine import etb_pkg::*; #(
  parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   valid_i,
  output logic   ready_o,
  input  lanes_t lanes_i,
  output logic   valid_o,
  input  logic   ready_i,
  output vec_t   vec_o
);

  localparam int   SH  = Q_FRAC - OUT_FRAC_BITS;
  localparam sum_t RND = (SH > 0) ? (sum_t'(1) <<< ((SH > 0) ? SH - 1 : 0)) : '0;
  localparam sum_t ONE = sum_t'(1) <<< OUT_FRAC_BITS;

  typedef struct packed {
    xy_t sp, sr, cr, cpcy, cpsy, spcy, spsy, srcp, crcp, crsy, srsy, crcy, srcy;
  } prod_a_t;

  typedef struct packed {
    xy_t sp, cpcy, cpsy, srcp, crcp, crsy, srsy, crcy, srcy;
    xy_t srspcy, srspsy, crspcy, crspsy;
  } prod_b_t;

  function automatic comp_t to_out(input sum_t v);
    sum_t r;
    begin
      r = (v + RND) >>> SH;
      if (r > ONE) begin
        r = ONE;
      end
      if (r < -ONE) begin
        r = -ONE;
      end
      return r[OUT_W-1:0];
    end
  endfunction

  logic    va_q, vb_q, vc_q;
  logic    ra, rb, rc;
  prod_a_t pa_q, pa_d;
  prod_b_t pb_q, pb_d;
  vec_t    vec_q, vec_d;

  assign rc      = !vc_q || ready_i;
  assign rb      = !vb_q || rc;
  assign ra      = !va_q || rb;
  assign ready_o = ra;

  // sine, cosine with fold sign, then first products
  always_comb begin
    xy_t s [N_AXES];
    xy_t c [N_AXES];
    for (int a = 0; a < N_AXES; a++) begin
      s[a] = lanes_i[a].neg ? -lanes_i[a].y : lanes_i[a].y;
      c[a] = lanes_i[a].neg ? -lanes_i[a].x : lanes_i[a].x;
    end
    pa_d.sp   = s[0];
    pa_d.sr   = s[2];
    pa_d.cr   = c[2];
    pa_d.cpcy = qmul(c[0], c[1]);
    pa_d.cpsy = qmul(c[0], s[1]);
    pa_d.spcy = qmul(s[0], c[1]);
    pa_d.spsy = qmul(s[0], s[1]);
    pa_d.srcp = qmul(s[2], c[0]);
    pa_d.crcp = qmul(c[2], c[0]);
    pa_d.crsy = qmul(c[2], s[1]);
    pa_d.srsy = qmul(s[2], s[1]);
    pa_d.crcy = qmul(c[2], c[1]);
    pa_d.srcy = qmul(s[2], c[1]);
  end

  // roll times pitch-yaw products
  always_comb begin
    pb_d.sp     = pa_q.sp;
    pb_d.cpcy   = pa_q.cpcy;
    pb_d.cpsy   = pa_q.cpsy;
    pb_d.srcp   = pa_q.srcp;
    pb_d.crcp   = pa_q.crcp;
    pb_d.crsy   = pa_q.crsy;
    pb_d.srsy   = pa_q.srsy;
    pb_d.crcy   = pa_q.crcy;
    pb_d.srcy   = pa_q.srcy;
    pb_d.srspcy = qmul(pa_q.sr, pa_q.spcy);
    pb_d.srspsy = qmul(pa_q.sr, pa_q.spsy);
    pb_d.crspcy = qmul(pa_q.cr, pa_q.spcy);
    pb_d.crspsy = qmul(pa_q.cr, pa_q.spsy);
  end

  // sums and output rounding
  always_comb begin
    vec_d.forward_x = to_out(P_W'(pb_q.cpcy));
    vec_d.forward_y = to_out(P_W'(pb_q.cpsy));
    vec_d.forward_z = to_out(-P_W'(pb_q.sp));
    vec_d.right_x   = to_out(P_W'(pb_q.crsy) - P_W'(pb_q.srspcy));
    vec_d.right_y   = to_out(-P_W'(pb_q.srspsy) - P_W'(pb_q.crcy));
    vec_d.right_z   = to_out(-P_W'(pb_q.srcp));
    vec_d.up_x      = to_out(P_W'(pb_q.crspcy) + P_W'(pb_q.srsy));
    vec_d.up_y      = to_out(P_W'(pb_q.crspsy) - P_W'(pb_q.srcy));
    vec_d.up_z      = to_out(P_W'(pb_q.crcp));
  end

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      if (ra) va_q <= valid_i;
      if (rb) vb_q <= va_q;
      if (rc) vc_q <= vb_q;
    end
  end

  // stage data
  always_ff @(posedge clk_i) begin
    if (valid_i && ra) pa_q  <= pa_d;
    if (va_q && rb)    pb_q  <= pb_d;
    if (vb_q && rc)    vec_q <= vec_d;
  end

  assign valid_o = vc_q;
  assign vec_o   = vec_q;

endmodule

// File: src/euler_to_basis_vectors.sv
// euler_to_basis_vectors: top level, angle fold stage, cordic cell chain and
// product stages. Depends on etb_pkg, etb_if, etb_reduce, etb_cordic_cell,
// etb_combine.

// Converts a pitch/yaw/roll triple (signed degrees, ANGLE_FRAC_BITS fraction
// bits, any 17-bit value, taken modulo 360) into the forward, right and up
// unit vectors as nine signed components with OUT_FRAC_BITS fraction bits.
// One triple is accepted every cycle unless a stalled output has filled all
// stages; its word passes one fold stage, one cordic cell per stage and three
// product stages. Every stage has its own valid bit, so a stalled output only
// blocks input once all stages are full and bubbles are squeezed out.
module euler_to_basis_vectors import etb_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
  parameter int OUT_FRAC_BITS   = OUT_FRAC_BITS_DEF,
  parameter int CORDIC_STAGES   = CORDIC_STAGES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  etb_angle_if.sink   in_i,
  etb_vec_if.source   out_o
);

  logic   valid [CORDIC_STAGES+1];
  logic   ready [CORDIC_STAGES+1];
  lanes_t lanes [CORDIC_STAGES+1];
  angle_t angles [N_AXES];
  vec_t   vec;

  assign angles[0] = in_i.pitch_angle;
  assign angles[1] = in_i.yaw_angle;
  assign angles[2] = in_i.roll_angle;

  // angle fold
  etb_reduce #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_reduce (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(in_i.valid),
    .ready_o(in_i.ready),
    .angle_i(angles),
    .valid_o(valid[0]),
    .ready_i(ready[0]),
    .lanes_o(lanes[0])
  );

  // cordic chain
  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    etb_cordic_cell #(
      .STAGE(g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(valid[g]),
      .ready_o(ready[g]),
      .lanes_i(lanes[g]),
      .valid_o(valid[g+1]),
      .ready_i(ready[g+1]),
      .lanes_o(lanes[g+1])
    );
  end

  // products and output word
  etb_combine #(
    .OUT_FRAC_BITS(OUT_FRAC_BITS)
  ) u_combine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(valid[CORDIC_STAGES]),
    .ready_o(ready[CORDIC_STAGES]),
    .lanes_i(lanes[CORDIC_STAGES]),
    .valid_o(out_o.valid),
    .ready_i(out_o.ready),
    .vec_o  (vec)
  );

  assign out_o.forward_x = vec.forward_x;
  assign out_o.forward_y = vec.forward_y;
  assign out_o.forward_z = vec.forward_z;
  assign out_o.right_x   = vec.right_x;
  assign out_o.right_y   = vec.right_y;
  assign out_o.right_z   = vec.right_z;
  assign out_o.up_x      = vec.up_x;
  assign out_o.up_y      = vec.up_y;
  assign out_o.up_z      = vec.up_z;

  // input only stalls when the output is stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (out_o.valid && !out_o.ready))
    else $error("input stalled without output back-pressure");

  // folded pitch lies within a quarter turn
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid[0] |-> (lanes[0][0].z <= (z_t'(90) <<< Z_FRAC) &&
                  lanes[0][0].z >= -(z_t'(90) <<< Z_FRAC)))
    else $error("pitch fold out of range");

  // a stalled word at the first cell holds its residual angle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid[1] && !ready[1]) |=> (lanes[1] == $past(lanes[1])))
    else $error("cordic stage changed while stalled");

endmodule

// File: tb/tb_euler_to_basis_vectors.sv
// tb_euler_to_basis_vectors: self-checking testbench for the angle triple to
// basis vector converter. Depends on etb_pkg, etb_if and the block itself.
module tb_euler_to_basis_vectors;
  timeunit 1ns;
  timeprecision 1ps;
  import etb_pkg::*;

  localparam int AF       = ANGLE_FRAC_BITS_DEF;
  localparam int OF       = OUT_FRAC_BITS_DEF;
  localparam int STAGES   = CORDIC_STAGES_DEF;
  localparam int LATENCY  = STAGES + 4;
  localparam int N_RANDOM = 640;
  localparam int N_PHASES = 4;

  typedef struct packed {
    angle_t pitch;
    angle_t yaw;
    angle_t roll;
  } triple_t;

  logic clk_i;
  logic rst_ni;

  etb_angle_if angle_ch ();
  etb_vec_if   vec_ch ();

  euler_to_basis_vectors dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (angle_ch.sink),
    .out_o  (vec_ch.source)
  );

  triple_t triples_to_send[$];
  vec_t    vectors_due[$];
  int      errors;
  int      sent;
  int      idle_pct;
  int      stall_pct;
  int      phase_len;

  // clock
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // arithmetic shift and q30 product, rounded half up
  function automatic longint q30_mul(input longint a, input longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  // sine and cosine in q30 of an angle, folded into [-90, 90] first
  function automatic void angle_sin_cos(input angle_t a, output longint s,
                                        output longint c);
    longint full_turn;
    longint r;
    longint x;
    longint y;
    longint z;
    longint xs;
    longint ys;
    longint step_angle;
    bit     flip;
    full_turn = 64'sd360 <<< AF;
    r = longint'(a) % full_turn;
    flip = 1'b0;
    if (r < 0) r += full_turn;
    if (r >= (64'sd180 <<< AF)) r -= full_turn;
    if (r > (64'sd90 <<< AF)) begin
      r -= (64'sd180 <<< AF);
      flip = 1'b1;
    end else if (r < -(64'sd90 <<< AF)) begin
      r += (64'sd180 <<< AF);
      flip = 1'b1;
    end
    z = r <<< (Z_FRAC - AF);
    x = CORDIC_X0;
    y = 0;
    for (int i = 0; i < STAGES; i++) begin
      case (i)
        0:  step_angle = 754974720;
        1:  step_angle = 445687602;
        2:  step_angle = 235489088;
        3:  step_angle = 119537938;
        4:  step_angle = 60000934;
        5:  step_angle = 30029717;
        6:  step_angle = 15018523;
        7:  step_angle = 7509720;
        8:  step_angle = 3754917;
        9:  step_angle = 1877466;
        10: step_angle = 938734;
        11: step_angle = 469367;
        default: step_angle = (DEG_PER_RAD_Z + (64'sd1 <<< (i - 1))) >>> i;
      endcase
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys;
        y += xs;
        z -= step_angle;
      end else begin
        x += ys;
        y -= xs;
        z += step_angle;
      end
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endfunction

  // q30 to output format, rounded half up and clamped to unity
  function automatic comp_t to_component(input longint v);
    longint r;
    r = (v + (64'sd1 <<< (Q_FRAC - OF - 1))) >>> (Q_FRAC - OF);
    if (r > (64'sd1 <<< OF)) r = 64'sd1 <<< OF;
    if (r < -(64'sd1 <<< OF)) r = -(64'sd1 <<< OF);
    return comp_t'(r);
  endfunction

  function automatic vec_t basis_of(input triple_t t);
    longint sp, cp, sy, cy, sr, cr, spcy, spsy;
    vec_t   v;
    angle_sin_cos(t.pitch, sp, cp);
    angle_sin_cos(t.yaw, sy, cy);
    angle_sin_cos(t.roll, sr, cr);
    spcy = q30_mul(sp, cy);
    spsy = q30_mul(sp, sy);
    v.forward_x = to_component(q30_mul(cp, cy));
    v.forward_y = to_component(q30_mul(cp, sy));
    v.forward_z = to_component(-sp);
    v.right_x   = to_component(-q30_mul(sr, spcy) + q30_mul(cr, sy));
    v.right_y   = to_component(-q30_mul(sr, spsy) - q30_mul(cr, cy));
    v.right_z   = to_component(-q30_mul(sr, cp));
    v.up_x      = to_component(q30_mul(cr, spcy) + q30_mul(sr, sy));
    v.up_y      = to_component(q30_mul(cr, spsy) - q30_mul(sr, cy));
    v.up_z      = to_component(q30_mul(cr, cp));
    return v;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d, expected %0d", what, got, want);
    errors++;
  endtask

  // sender: next word or an idle cycle, only when the current one is taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_ch.valid       <= 1'b0;
      angle_ch.pitch_angle <= '0;
      angle_ch.yaw_angle   <= '0;
      angle_ch.roll_angle  <= '0;
    end else if (!angle_ch.valid || angle_ch.ready) begin
      if (triples_to_send.size() > 0 && $urandom_range(99) >= idle_pct) begin
        angle_ch.valid       <= 1'b1;
        angle_ch.pitch_angle <= triples_to_send[0].pitch;
        angle_ch.yaw_angle   <= triples_to_send[0].yaw;
        angle_ch.roll_angle  <= triples_to_send[0].roll;
        void'(triples_to_send.pop_front());
      end else begin
        angle_ch.valid <= 1'b0;
      end
    end
  end

  // receiver stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vec_ch.ready <= 1'b0;
    else         vec_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // predict on accepted angles, check accepted words
  always @(posedge clk_i) begin
    vec_t got;
    vec_t want;
    if (rst_ni && angle_ch.valid && angle_ch.ready) begin
      vectors_due.push_back(basis_of({angle_ch.pitch_angle, angle_ch.yaw_angle,
                                      angle_ch.roll_angle}));
      sent++;
    end
    if (rst_ni && vec_ch.valid && vec_ch.ready) begin
      got = {vec_ch.forward_x, vec_ch.forward_y, vec_ch.forward_z,
             vec_ch.right_x, vec_ch.right_y, vec_ch.right_z,
             vec_ch.up_x, vec_ch.up_y, vec_ch.up_z};
      if (vectors_due.size() == 0) begin
        $display("unexpected word on output");
        errors++;
      end else begin
        want = vectors_due.pop_front();
        if (got.forward_x !== want.forward_x)
          report_mismatch("forward_x", got.forward_x, want.forward_x);
        if (got.forward_y !== want.forward_y)
          report_mismatch("forward_y", got.forward_y, want.forward_y);
        if (got.forward_z !== want.forward_z)
          report_mismatch("forward_z", got.forward_z, want.forward_z);
        if (got.right_x !== want.right_x)
          report_mismatch("right_x", got.right_x, want.right_x);
        if (got.right_y !== want.right_y)
          report_mismatch("right_y", got.right_y, want.right_y);
        if (got.right_z !== want.right_z)
          report_mismatch("right_z", got.right_z, want.right_z);
        if (got.up_x !== want.up_x) report_mismatch("up_x", got.up_x, want.up_x);
        if (got.up_y !== want.up_y) report_mismatch("up_y", got.up_y, want.up_y);
        if (got.up_z !== want.up_z) report_mismatch("up_z", got.up_z, want.up_z);
      end
    end
  end

  // idle and stall pattern follows the number of angle words taken so far
  always @(posedge clk_i) begin
    case ((sent / phase_len) % N_PHASES)
      0: begin idle_pct <= 0;  stall_pct <= 0;  end
      1: begin idle_pct <= 87; stall_pct <= 0;  end
      2: begin idle_pct <= 0;  stall_pct <= 87; end
      default: begin idle_pct <= 38; stall_pct <= 38; end
    endcase
  end

  // directed angles: zero, quadrant edges, fold boundaries, range extremes
  localparam int N_DIRECTED = 18;
  localparam triple_t DIRECTED[N_DIRECTED] = '{
    '{17'sd0,      17'sd0,      17'sd0},
    '{17'sd11520,  17'sd0,      17'sd0},
    '{-17'sd11520, 17'sd0,      17'sd0},
    '{17'sd0,      17'sd11520,  17'sd0},
    '{17'sd0,      17'sd0,      17'sd11520},
    '{17'sd23040,  -17'sd23040, 17'sd23040},
    '{17'sd46080,  17'sd46080,  17'sd46080},
    '{-17'sd46080, -17'sd46080, -17'sd46080},
    '{17'sd65535,  17'sd65535,  17'sd65535},
    '{-17'sd65536, -17'sd65536, -17'sd65536},
    '{17'sd65535,  -17'sd65536, 17'sd0},
    '{17'sd11521,  -17'sd11521, 17'sd11519},
    '{17'sd34560,  17'sd5760,   -17'sd34560},
    '{17'sd1,      -17'sd1,     17'sd1},
    '{17'sd5760,   17'sd5760,   17'sd5760},
    '{17'sd23039,  17'sd23041,  -17'sd23041},
    '{17'sd45000,  -17'sd1000,  17'sd12345},
    '{-17'sd20000, 17'sd30000,  -17'sd40000}
  };

  initial begin
    triple_t t;
    rst_ni            = 1'b0;
    errors            = 0;
    sent              = 0;
    idle_pct          = 0;
    stall_pct         = 0;
    phase_len         = (N_DIRECTED + N_RANDOM) / N_PHASES + 1;
    angle_ch.valid    = 1'b0;
    angle_ch.pitch_angle = '0;
    angle_ch.yaw_angle   = '0;
    angle_ch.roll_angle  = '0;
    vec_ch.ready      = 1'b0;
    foreach (DIRECTED[i]) triples_to_send.push_back(DIRECTED[i]);
    // random angles, mostly over the full pattern range, some in +-360 deg
    for (int i = 0; i < N_RANDOM; i++) begin
      if ($urandom_range(3) == 0) begin
        t.pitch = angle_t'($signed($urandom_range(92160)) - 46080);
        t.yaw   = angle_t'($signed($urandom_range(92160)) - 46080);
        t.roll  = angle_t'($signed($urandom_range(92160)) - 46080);
      end else begin
        t.pitch = angle_t'($urandom);
        t.yaw   = angle_t'($urandom);
        t.roll  = angle_t'($urandom);
      end
      triples_to_send.push_back(t);
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    // every word taken and every expected vector checked
    wait (sent == N_DIRECTED + N_RANDOM && vectors_due.size() == 0);
    repeat (LATENCY * 2) @(posedge clk_i);
    if (errors == 0) $display("status: pass");
    else             $display("status: fail");
    $finish;
  end

  // overall time limit
  initial begin
    #5ms;
    $display("status: fail");
    $finish;
  end

endmodule

// File: euler_to_basis_vectors.f
src/etb_pkg.sv
src/etb_if.sv
src/etb_reduce.sv
src/etb_cordic_cell.sv
src/etb_combine.sv
src/euler_to_basis_vectors.sv
tb/tb_euler_to_basis_vectors.sv
